// ===== hw/rtl/tdq_pkg.sv =====
`default_nettype none

package tdq_pkg;

	localparam int DEPTH = 16;
	localparam int ID_W  = 32;
	localparam int OCC_W = 5;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SUM_W = CNT_W + 1;

	localparam logic [1:0] MODE_PUSH    = 2'd0;
	localparam logic [1:0] MODE_POP_OLD = 2'd1;
	localparam logic [1:0] MODE_POP_NEW = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_DUP   = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_FULL  = 2'd3;

	typedef struct packed {
		logic load;
		logic scan_rd;
		logic pop_rd;
		logic exec;
	} dp_cmd_t;

	typedef struct packed {
		logic in_push;
		logic in_pop;
		logic scan_done;
		logic out_free;
	} dp_stat_t;

	function automatic logic [PTR_W-1:0] slot_add(input logic [PTR_W-1:0] base,
			input logic [CNT_W-1:0] off);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(base) + SUM_W'(off);
		if (sum >= SUM_W'(DEPTH)) begin
			sum = sum - SUM_W'(DEPTH);
		end
		return sum[PTR_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/task_deque_with_dedup.sv =====
// Task store with duplicate rejection, worked as a double-ended queue.
// Input channel (in_valid/in_ready) carries mode and task_id: push task_id
// at the newest end, pop the oldest entry, or pop the newest entry.
// Output channel (out_valid/out_ready) returns one transaction per command:
// status (ok, duplicate, empty, full), popped_id and occupancy after it.
// A push scans the stored entries through one read port of the entry RAM,
// one entry per cycle. One command is in work at a time. The result sits
// in an output register: in_ready rises again as soon as the command has
// finished, while the result still waits.
// A stalled receiver holds the result; a following command is then worked
// up to its final step and waits there until the output register frees.
// Reset empties the store at once (count and oldest slot cleared); the
// entry RAM is not cleared and no clearing pass is needed.
`default_nettype none

module task_deque_with_dedup (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [1:0]           mode,
	input  wire logic [31:0]          task_id,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [1:0]                status,
	output logic [31:0]               popped_id,
	output logic [tdq_pkg::OCC_W-1:0] occupancy
);

	tdq_pkg::dp_cmd_t  cmd;
	tdq_pkg::dp_stat_t st;

	tdq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	tdq_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.mode      (mode),
		.task_id   (task_id),
		.out_ready (out_ready),
		.cmd       (cmd),
		.st        (st),
		.out_valid (out_valid),
		.status    (status),
		.popped_id (popped_id),
		.occupancy (occupancy)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/tdq_ctrl.sv =====
`default_nettype none

module tdq_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire tdq_pkg::dp_stat_t st,
	output tdq_pkg::dp_cmd_t       cmd
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SCAN  = 4'b0010,
		S_POPRD = 4'b0100,
		S_EXEC  = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		in_ready    = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (st.in_push) begin
						state_d = S_SCAN;
					end else if (st.in_pop) begin
						state_d = S_POPRD;
					end else begin
						state_d = S_EXEC;
					end
				end
			end
			S_SCAN: begin
				if (st.scan_done) begin
					state_d = S_EXEC;
				end else begin
					cmd.scan_rd = 1'b1;
				end
			end
			S_POPRD: begin
				cmd.pop_rd = 1'b1;
				state_d    = S_EXEC;
			end
			S_EXEC: begin
				if (st.out_free) begin
					cmd.exec = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/tdq_dp.sv =====
`default_nettype none

module tdq_dp (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic [1:0]               mode,
	input  wire logic [31:0]              task_id,
	input  wire logic                     out_ready,
	input  wire tdq_pkg::dp_cmd_t         cmd,
	output tdq_pkg::dp_stat_t             st,
	output logic                          out_valid,
	output logic [1:0]                    status,
	output logic [31:0]                   popped_id,
	output logic [tdq_pkg::OCC_W-1:0]     occupancy
);

	logic [tdq_pkg::ID_W-1:0]  mem_q [tdq_pkg::DEPTH];
	logic [tdq_pkg::ID_W-1:0]  rdata_q;
	logic                      rd_vld_q;
	logic [1:0]                mode_q;
	logic [tdq_pkg::ID_W-1:0]  id_q;
	logic [tdq_pkg::CNT_W-1:0] idx_q;
	logic                      dup_q;
	logic [tdq_pkg::PTR_W-1:0] oldest_q;
	logic [tdq_pkg::CNT_W-1:0] count_q;
	logic                      out_valid_q;
	logic [1:0]                status_q;
	logic [31:0]               popped_q;
	logic [tdq_pkg::OCC_W-1:0] occ_q;

	logic                      rd_en;
	logic [tdq_pkg::PTR_W-1:0] rd_addr;
	logic                      wr_en;
	logic [tdq_pkg::PTR_W-1:0] wr_addr;
	logic                      is_push;
	logic                      is_pop;
	logic                      full;
	logic                      empty;
	logic [1:0]                status_d;
	logic [tdq_pkg::ID_W-1:0]  popped_d;
	logic [tdq_pkg::CNT_W-1:0] count_d;
	logic [tdq_pkg::PTR_W-1:0] oldest_d;

	assign is_push = (mode_q == tdq_pkg::MODE_PUSH);
	assign is_pop  = (mode_q == tdq_pkg::MODE_POP_OLD) || (mode_q == tdq_pkg::MODE_POP_NEW);
	assign full    = (count_q == tdq_pkg::CNT_W'(tdq_pkg::DEPTH));
	assign empty   = (count_q == '0);

	assign st.in_push   = (mode == tdq_pkg::MODE_PUSH);
	assign st.in_pop    = (mode == tdq_pkg::MODE_POP_OLD) || (mode == tdq_pkg::MODE_POP_NEW);
	assign st.scan_done = (idx_q == count_q);
	assign st.out_free  = !out_valid_q || out_ready;

	assign rd_en = cmd.scan_rd || cmd.pop_rd;

	always_comb begin
		if (cmd.pop_rd) begin
			if (mode_q == tdq_pkg::MODE_POP_OLD) begin
				rd_addr = oldest_q;
			end else begin
				rd_addr = tdq_pkg::slot_add(oldest_q, count_q - tdq_pkg::CNT_W'(1));
			end
		end else begin
			rd_addr = tdq_pkg::slot_add(oldest_q, idx_q);
		end
	end

	always_comb begin
		status_d = tdq_pkg::ST_OK;
		popped_d = '0;
		count_d  = count_q;
		oldest_d = oldest_q;
		wr_en    = 1'b0;
		wr_addr  = tdq_pkg::slot_add(oldest_q, count_q);
		if (is_push) begin
			if (dup_q) begin
				status_d = tdq_pkg::ST_DUP;
			end else if (full) begin
				status_d = tdq_pkg::ST_FULL;
			end else begin
				wr_en   = cmd.exec;
				count_d = count_q + tdq_pkg::CNT_W'(1);
			end
		end else if (is_pop) begin
			if (empty) begin
				status_d = tdq_pkg::ST_EMPTY;
			end else begin
				popped_d = rdata_q;
				count_d  = count_q - tdq_pkg::CNT_W'(1);
				if (mode_q == tdq_pkg::MODE_POP_OLD) begin
					oldest_d = tdq_pkg::slot_add(oldest_q, tdq_pkg::CNT_W'(1));
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= id_q;
		end
		if (rd_en) begin
			rdata_q <= mem_q[rd_addr];
		end
		if (cmd.load) begin
			mode_q <= mode;
			id_q   <= tdq_pkg::ID_W'(task_id);
		end
		if (cmd.exec) begin
			status_q <= status_d;
			popped_q <= 32'(popped_d);
			occ_q    <= tdq_pkg::OCC_W'(count_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_q    <= 1'b0;
			idx_q       <= '0;
			dup_q       <= 1'b0;
			oldest_q    <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_q <= cmd.scan_rd;
			if (cmd.load) begin
				idx_q <= '0;
				dup_q <= 1'b0;
			end else begin
				if (cmd.scan_rd) begin
					idx_q <= idx_q + tdq_pkg::CNT_W'(1);
				end
				if (rd_vld_q && (rdata_q == id_q)) begin
					dup_q <= 1'b1;
				end
			end
			if (cmd.exec) begin
				count_q     <= count_d;
				oldest_q    <= oldest_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign popped_id = popped_q;
	assign occupancy = occ_q;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= tdq_pkg::CNT_W'(tdq_pkg::DEPTH))
		else $error("stored count exceeds depth");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_rd |-> (idx_q < count_q))
		else $error("scan read beyond occupied entries");

	a_exec_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> out_valid_q)
		else $error("executed command left no result");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && is_push && !dup_q && !full) |=>
		(count_q == $past(count_q) + tdq_pkg::CNT_W'(1)))
		else $error("accepted push did not grow the store");
`endif

endmodule

`default_nettype wire

// ===== verif/task_deque_with_dedup_tb.sv =====
module task_deque_with_dedup_tb;
	import tdq_pkg::*;

	localparam logic [1:0] MODE_NOP = 2'd3;
	localparam int RAND_ITEMS  = 1000;
	localparam int STEADY_TAIL = 150;
	localparam int HOLD_OFF    = 300;
	localparam int HOLD_AT     = 400;
	localparam int PAUSE_AT    = 600;
	localparam int QUIET_LIMIT = 3000;
	localparam int DRAIN       = 40;

	typedef struct packed {
		logic [1:0]       st;
		logic [ID_W-1:0]  pid;
		logic [OCC_W-1:0] occ;
	} result_t;

	typedef struct packed {
		logic [1:0]      cmd;
		logic [ID_W-1:0] id;
		logic [4:0]      reps;
		logic            typed;
		result_t         want;
	} step_t;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	logic [1:0]       mode;
	logic [31:0]      task_id;
	logic             out_valid;
	logic             out_ready;
	logic [1:0]       status;
	logic [31:0]      popped_id;
	logic [OCC_W-1:0] occupancy;

	logic [ID_W-1:0] pending_tasks[$];
	result_t         due_results[$];
	result_t         head;
	step_t           steps [0:13];
	int              mismatch_cnt = 0;
	int              taken_cnt = 0;
	int              quiet = 0;
	bit              steady = 1'b0;

	task_deque_with_dedup dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.task_id   (task_id),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.popped_id (popped_id),
		.occupancy (occupancy)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic result_t predict_cmd(input logic [1:0] cmd, input logic [ID_W-1:0] id);
		result_t r;
		bit      dup;
		r = '0;
		dup = 1'b0;
		if (cmd == MODE_PUSH) begin
			foreach (pending_tasks[i])
				if (pending_tasks[i] == id)
					dup = 1'b1;
			if (dup)
				r.st = ST_DUP;
			else if (pending_tasks.size() >= DEPTH)
				r.st = ST_FULL;
			else
				pending_tasks = {pending_tasks, id};
		end else if (cmd == MODE_POP_OLD || cmd == MODE_POP_NEW) begin
			if (pending_tasks.size() == 0)
				r.st = ST_EMPTY;
			else if (cmd == MODE_POP_OLD)
				r.pid = pending_tasks.pop_front();
			else begin
				r.pid = pending_tasks[pending_tasks.size() - 1];
				pending_tasks.delete(pending_tasks.size() - 1);
			end
		end
		r.occ = OCC_W'(pending_tasks.size());
		return r;
	endfunction

	task automatic note_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		mismatch_cnt++;
		if (mismatch_cnt <= 40)
			$display("%0t: %s got %h, expected %h", $time, field, got, want);
	endtask

	task automatic drive_cmd(input logic [1:0] cmd, input logic [ID_W-1:0] id);
		in_valid <= 1'b1;
		mode     <= cmd;
		task_id  <= id;
		do @(posedge clk); while (!in_ready);
		taken_cnt++;
	endtask

	task automatic idle_for(input int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (due_results.size() != 0);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (due_results.size() == 0) begin
				note_mismatch("unexpected transaction, status", status, '0);
			end else begin
				head = due_results.pop_front();
				if (status !== head.st)
					note_mismatch("status", status, head.st);
				if (popped_id !== head.pid)
					note_mismatch("popped_id", popped_id, head.pid);
				if (occupancy !== head.occ)
					note_mismatch("occupancy", occupancy, head.occ);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet == QUIET_LIMIT) begin
			$display("task_deque_with_dedup: mismatch");
			$finish;
		end
	end

	initial begin : receiver
		int n;
		bit long_done;
		out_ready = 1'b0;
		long_done = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (steady) begin
				out_ready <= 1'b1;
				n = 1;
			end else if (!long_done && taken_cnt >= HOLD_AT) begin
				long_done = 1'b1;
				out_ready <= 1'b0;
				n = HOLD_OFF;
			end else if ($urandom_range(2) == 0) begin
				out_ready <= 1'b0;
				n = $urandom_range(1, 11);
			end else begin
				out_ready <= 1'b1;
				n = $urandom_range(1, 40);
			end
			repeat (n) @(posedge clk);
		end
	end

	initial begin : sender
		int              n_rand;
		int              push_pct;
		int              pick;
		bit              idle_on;
		bit              paused;
		logic [1:0]      cmd;
		logic [ID_W-1:0] id;
		result_t         r;

		arst_n   = 1'b0;
		in_valid = 1'b0;
		mode     = MODE_PUSH;
		task_id  = '0;
		push_pct = 50;
		idle_on  = 1'b0;
		paused   = 1'b0;

		steps = '{
			'{MODE_POP_OLD, 32'h0000_0000, 5'd1,  1'b1, '{ST_EMPTY, 32'h0000_0000, 5'd0}},
			'{MODE_POP_NEW, 32'hFFFF_FFFF, 5'd1,  1'b1, '{ST_EMPTY, 32'h0000_0000, 5'd0}},
			'{MODE_PUSH,    32'h0000_0000, 5'd1,  1'b1, '{ST_OK,    32'h0000_0000, 5'd1}},
			'{MODE_PUSH,    32'hFFFF_FFFF, 5'd1,  1'b1, '{ST_OK,    32'h0000_0000, 5'd2}},
			'{MODE_PUSH,    32'h0000_0000, 5'd1,  1'b1, '{ST_DUP,   32'h0000_0000, 5'd2}},
			'{MODE_POP_NEW, 32'h0000_0000, 5'd1,  1'b1, '{ST_OK,    32'hFFFF_FFFF, 5'd1}},
			'{MODE_POP_OLD, 32'h0000_0000, 5'd1,  1'b1, '{ST_OK,    32'h0000_0000, 5'd0}},
			'{MODE_NOP,     32'hFFFF_FFFF, 5'd1,  1'b1, '{ST_OK,    32'h0000_0000, 5'd0}},
			'{MODE_PUSH,    32'hA5A5_0000, 5'd16, 1'b0, '{ST_OK,    32'h0000_0000, 5'd0}},
			'{MODE_PUSH,    32'h0000_0000, 5'd1,  1'b1, '{ST_FULL,  32'h0000_0000, 5'd16}},
			'{MODE_PUSH,    32'hA5A5_000F, 5'd1,  1'b1, '{ST_DUP,   32'h0000_0000, 5'd16}},
			'{MODE_NOP,     32'h0000_0000, 5'd1,  1'b1, '{ST_OK,    32'h0000_0000, 5'd16}},
			'{MODE_POP_OLD, 32'h0000_0000, 5'd1,  1'b1, '{ST_OK,    32'hA5A5_0000, 5'd15}},
			'{MODE_POP_NEW, 32'h0000_0000, 5'd1,  1'b1, '{ST_OK,    32'hA5A5_000F, 5'd14}}
		};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (steps[s]) begin
			for (int k = 0; k < steps[s].reps; k++) begin
				cmd = steps[s].cmd;
				id  = steps[s].id + k;
				drive_cmd(cmd, id);
				r = predict_cmd(cmd, id);
				if (steps[s].typed)
					r = steps[s].want;
				due_results = {due_results, r};
			end
		end

		n_rand = 0;
		while (n_rand < RAND_ITEMS) begin
			if (n_rand % 40 == 0) begin
				pick     = $urandom_range(2);
				push_pct = (pick == 0) ? 15 : (pick == 1) ? 50 : 85;
				idle_on  = ($urandom_range(3) != 0);
			end
			if (n_rand >= RAND_ITEMS - STEADY_TAIL)
				steady = 1'b1;
			if (!paused && n_rand >= PAUSE_AT) begin
				paused = 1'b1;
				wait_drained();
			end else if (!steady && idle_on && $urandom_range(3) == 0) begin
				idle_for($urandom_range(1, 11));
			end

			if ($urandom_range(99) < 3)
				cmd = MODE_NOP;
			else if ($urandom_range(99) < push_pct)
				cmd = MODE_PUSH;
			else
				cmd = $urandom_range(1) ? MODE_POP_OLD : MODE_POP_NEW;

			pick = $urandom_range(9);
			if (pick < 3 && pending_tasks.size() != 0)
				id = pending_tasks[$urandom_range(pending_tasks.size() - 1)];
			else if (pick < 6)
				id = $urandom_range(31);
			else
				id = $urandom;

			drive_cmd(cmd, id);
			r = predict_cmd(cmd, id);
			due_results = {due_results, r};
			if (cmd != MODE_NOP)
				n_rand++;
		end

		wait_drained();
		repeat (DRAIN) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("task_deque_with_dedup: match");
		else
			$display("task_deque_with_dedup: mismatch");
		$finish;
	end

endmodule
